### rtl/arming_sequencer_ir_burst_unit_defines.svh
// assertion helpers for the arming sequencer
`ifndef ARMING_SEQUENCER_IR_BURST_UNIT_DEFINES_SVH
`define ARMING_SEQUENCER_IR_BURST_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ASIB_ASSERT_IMPLY(label, clk_s, rst_s, pre, post, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ASIB_ASSERT_NEXT(label, clk_s, rst_s, pre, post, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/asib_pkg.sv
`default_nettype none

package asib_pkg;

    // fixed field widths
    localparam int CODE_W      = 11;
    localparam int BIN_W       = 16;
    localparam int TIMER_CFG_W = 24;
    localparam int SHOTS_W     = 16;
    localparam int MODE_W      = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // default parameter values
    localparam int DEF_CODE_LEN   = 11;
    localparam int DEF_SIDE_BIT   = 5;
    localparam int DEF_LEAD_TICKS = 10;
    localparam int DEF_TIMER_BITS = 24;
    localparam int DEF_COUNT_BITS = 16;

    // register reset values
    localparam logic [CODE_W-1:0]      RST_CODE_PATTERN   = '0;
    localparam logic                   RST_SIDE_OPFOR     = 1'b0;
    localparam logic [BIN_W-1:0]       RST_BIN_TICKS      = 16'd500;
    localparam logic [BIN_W-1:0]       RST_PULSE_TICKS    = 16'd250;
    localparam logic [TIMER_CFG_W-1:0] RST_HOLD_TICKS     = 24'd800000;
    localparam logic [TIMER_CFG_W-1:0] RST_EXPENDED_TICKS = 24'd5000000;
    localparam logic [TIMER_CFG_W-1:0] RST_CONFIRM_TICKS  = 24'd12000;

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CODE_PATTERN   = 3'd0,
        REG_SIDE_OPFOR     = 3'd1,
        REG_BIN_TICKS      = 3'd2,
        REG_PULSE_TICKS    = 3'd3,
        REG_HOLD_TICKS     = 3'd4,
        REG_EXPENDED_TICKS = 3'd5,
        REG_CONFIRM_TICKS  = 3'd6
    } cfg_index_t;

    // mode codes as seen on the result
    localparam logic [MODE_W-1:0] MODE_CODE_SAFE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_READY    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_FLY      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CODE_SENSE    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CODE_FLASH    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CODE_EXPENDED = 3'd5;

    // arming sequence state
    typedef enum logic [5:0] {
        MODE_SAFE     = 6'b000001,
        MODE_READY    = 6'b000010,
        MODE_FLY      = 6'b000100,
        MODE_SENSE    = 6'b001000,
        MODE_FLASH    = 6'b010000,
        MODE_EXPENDED = 6'b100000
    } mode_t;

    // burst sub-state
    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_LEAD   = 4'b0010,
        PH_BITS   = 4'b0100,
        PH_WINDOW = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [CODE_W-1:0]      code_pattern;
        logic                   side_opfor;
        logic [BIN_W-1:0]       bin_ticks;
        logic [BIN_W-1:0]       pulse_ticks;
        logic [TIMER_CFG_W-1:0] hold_ticks;
        logic [TIMER_CFG_W-1:0] expended_ticks;
        logic [TIMER_CFG_W-1:0] confirm_ticks;
    } asib_cfg_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  wdata;
    } asib_cfg_write_t;

    typedef struct packed {
        logic power_down;
        logic limit_on;
        logic altitude_ok;
        logic fire_request;
        logic ir_seen;
    } asib_item_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic               ir_drive;
        logic               safe_lamp;
        logic               armed_lamp;
        logic               spent_lamp;
        logic [SHOTS_W-1:0] shots;
        logic               confirmed;
        logic               burst_start;
    } asib_result_t;

    // state to output code
    function automatic logic [MODE_W-1:0] mode_code(mode_t m);
        logic [MODE_W-1:0] code;
        unique case (m)
            MODE_SAFE:     code = MODE_CODE_SAFE;
            MODE_READY:    code = MODE_CODE_READY;
            MODE_FLY:      code = MODE_CODE_FLY;
            MODE_SENSE:    code = MODE_CODE_SENSE;
            MODE_FLASH:    code = MODE_CODE_FLASH;
            MODE_EXPENDED: code = MODE_CODE_EXPENDED;
            default:       code = MODE_CODE_SAFE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

### rtl/asib_chan_if.sv
`default_nettype none

interface asib_chan_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/asib_cfg_regs.sv
`default_nettype none

module asib_cfg_regs (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      wr_en,
    input  wire asib_pkg::asib_cfg_write_t wr,
    output asib_pkg::asib_cfg_t            cfg
);
    import asib_pkg::*;

    asib_cfg_t cfg_reg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_pattern   <= RST_CODE_PATTERN;
            cfg_reg.side_opfor     <= RST_SIDE_OPFOR;
            cfg_reg.bin_ticks      <= RST_BIN_TICKS;
            cfg_reg.pulse_ticks    <= RST_PULSE_TICKS;
            cfg_reg.hold_ticks     <= RST_HOLD_TICKS;
            cfg_reg.expended_ticks <= RST_EXPENDED_TICKS;
            cfg_reg.confirm_ticks  <= RST_CONFIRM_TICKS;
        end
        else if (wr_en)
        begin
            unique case (wr.index)
                REG_CODE_PATTERN:   cfg_reg.code_pattern   <= wr.wdata[CODE_W-1:0];
                REG_SIDE_OPFOR:     cfg_reg.side_opfor     <= wr.wdata[0];
                REG_BIN_TICKS:      cfg_reg.bin_ticks      <= wr.wdata[BIN_W-1:0];
                REG_PULSE_TICKS:    cfg_reg.pulse_ticks    <= wr.wdata[BIN_W-1:0];
                REG_HOLD_TICKS:     cfg_reg.hold_ticks     <= wr.wdata[TIMER_CFG_W-1:0];
                REG_EXPENDED_TICKS: cfg_reg.expended_ticks <= wr.wdata[TIMER_CFG_W-1:0];
                REG_CONFIRM_TICKS:  cfg_reg.confirm_ticks  <= wr.wdata[TIMER_CFG_W-1:0];
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/asib_seq.sv
`default_nettype none

module asib_seq #(
    parameter int CODE_LEN   = asib_pkg::DEF_CODE_LEN,
    parameter int SIDE_BIT   = asib_pkg::DEF_SIDE_BIT,
    parameter int LEAD_TICKS = asib_pkg::DEF_LEAD_TICKS,
    parameter int TIMER_BITS = asib_pkg::DEF_TIMER_BITS,
    parameter int COUNT_BITS = asib_pkg::DEF_COUNT_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire asib_pkg::asib_item_t   item,
    input  wire asib_pkg::asib_cfg_t    cfg,
    output asib_pkg::asib_result_t      res
);
    import asib_pkg::*;

    localparam int POS_W = $clog2(CODE_LEN + 1);
    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    mode_t                 mode_reg, mode_next;
    phase_t                phase_reg, phase_next;
    logic                  power_held_reg, power_held_next;
    logic [TIMER_BITS-1:0] hold_count_reg, hold_count_next;
    logic [TIMER_BITS-1:0] expend_count_reg, expend_count_next;
    logic [POS_W-1:0]      bit_position_reg, bit_position_next;
    logic [BIN_W-1:0]      bin_count_reg, bin_count_next;
    logic [TIMER_BITS-1:0] window_count_reg, window_count_next;
    logic [COUNT_BITS-1:0] shot_total_reg, shot_total_next;
    logic                  confirm_flag_reg, confirm_flag_next;
    logic                  drive;
    logic                  start;

    logic [CODE_LEN+CODE_W-1:0] code_wide;
    logic [CODE_LEN-1:0]        frame_base;
    logic [CODE_LEN-1:0]        frame_vec;

    // frame bits with the side bit forced in
    assign code_wide  = {{CODE_LEN{1'b0}}, cfg.code_pattern};
    assign frame_base = code_wide[CODE_LEN-1:0];

    generate
        if (SIDE_BIT < CODE_LEN)
        begin : g_side
            always_comb
            begin
                frame_vec           = frame_base;
                frame_vec[SIDE_BIT] = cfg.side_opfor;
            end
        end
        else
        begin : g_no_side
            assign frame_vec = frame_base;
        end
    endgenerate

    // one tick of the sequence
    always_comb
    begin
        logic [CODE_LEN-1:0]   shifted;
        logic                  bit_val;
        logic [BIN_W-1:0]      len;
        logic [BIN_W:0]        bc_inc;
        logic [POS_W-1:0]      pos_inc;
        mode_t                 mode_mid;

        mode_next         = mode_reg;
        phase_next        = phase_reg;
        power_held_next   = power_held_reg;
        hold_count_next   = hold_count_reg;
        expend_count_next = expend_count_reg;
        bit_position_next = bit_position_reg;
        bin_count_next    = bin_count_reg;
        window_count_next = window_count_reg;
        shot_total_next   = shot_total_reg;
        confirm_flag_next = confirm_flag_reg;
        drive             = 1'b0;
        start             = 1'b0;
        shifted           = '0;
        bit_val           = 1'b0;
        len               = '0;
        bc_inc            = '0;
        pos_inc           = '0;

        // power button and fire, not serviced during a burst
        mode_mid = mode_reg;
        if (mode_mid != MODE_FLASH)
        begin
            if (item.power_down)
            begin
                if (!power_held_next)
                begin
                    power_held_next = 1'b1;
                    hold_count_next = '0;
                end
                else if (hold_count_next != TMAX)
                begin
                    hold_count_next = hold_count_next + 1'b1;
                end
                if (32'(hold_count_next) >= 32'(cfg.hold_ticks))
                begin
                    mode_mid          = (mode_mid == MODE_SAFE) ? MODE_READY : MODE_SAFE;
                    power_held_next   = 1'b0;
                    expend_count_next = '0;
                end
            end
            else
            begin
                power_held_next = 1'b0;
            end
            if (item.fire_request && mode_mid == MODE_SENSE)
            begin
                mode_mid   = MODE_FLASH;
                phase_next = PH_IDLE;
            end
        end

        // sequence step
        mode_next = mode_mid;
        unique case (mode_mid)
            MODE_READY:
            begin
                if (item.limit_on)
                    mode_next = MODE_FLY;
            end
            MODE_FLY:
            begin
                if (!item.limit_on)
                    mode_next = MODE_SENSE;
            end
            MODE_SENSE:
            begin
                if (item.altitude_ok)
                begin
                    mode_next  = MODE_FLASH;
                    phase_next = PH_IDLE;
                end
            end
            MODE_FLASH:
            begin
                // burst start
                if (phase_next == PH_IDLE)
                begin
                    start = 1'b1;
                    if (shot_total_next != CMAX)
                        shot_total_next = shot_total_next + 1'b1;
                    confirm_flag_next = 1'b0;
                    bin_count_next    = '0;
                    bit_position_next = '0;
                    window_count_next = '0;
                    phase_next        = (LEAD_TICKS > 0) ? PH_LEAD : PH_BITS;
                end
                case (phase_next)
                    PH_LEAD:
                    begin
                        bc_inc = {1'b0, bin_count_next} + 1'b1;
                        if (bc_inc >= (BIN_W + 1)'(LEAD_TICKS))
                        begin
                            phase_next        = PH_BITS;
                            bin_count_next    = '0;
                            bit_position_next = '0;
                        end
                        else
                        begin
                            bin_count_next = bc_inc[BIN_W-1:0];
                        end
                    end
                    PH_BITS:
                    begin
                        shifted = frame_vec >> bit_position_next;
                        bit_val = shifted[0];
                        len = (bit_val && cfg.pulse_ticks > cfg.bin_ticks) ?
                              cfg.pulse_ticks : cfg.bin_ticks;
                        if (len == '0)
                            len = BIN_W'(1);
                        drive  = bit_val && (bin_count_next < cfg.pulse_ticks);
                        bc_inc = {1'b0, bin_count_next} + 1'b1;
                        if (bc_inc >= {1'b0, len})
                        begin
                            bin_count_next    = '0;
                            pos_inc           = bit_position_next + 1'b1;
                            bit_position_next = pos_inc;
                            if (32'(pos_inc) >= 32'(CODE_LEN))
                            begin
                                window_count_next = '0;
                                if (cfg.confirm_ticks == '0)
                                begin
                                    mode_next         = MODE_EXPENDED;
                                    expend_count_next = '0;
                                    phase_next        = PH_IDLE;
                                end
                                else
                                begin
                                    phase_next = PH_WINDOW;
                                end
                            end
                        end
                        else
                        begin
                            bin_count_next = bc_inc[BIN_W-1:0];
                        end
                    end
                    PH_WINDOW:
                    begin
                        if (item.ir_seen &&
                            32'(window_count_next) < 32'(cfg.confirm_ticks))
                        begin
                            confirm_flag_next = 1'b1;
                            mode_next         = MODE_EXPENDED;
                            expend_count_next = '0;
                            phase_next        = PH_IDLE;
                        end
                        else
                        begin
                            if (window_count_next != TMAX)
                                window_count_next = window_count_next + 1'b1;
                            if (32'(window_count_next) >= 32'(cfg.confirm_ticks))
                            begin
                                mode_next         = MODE_EXPENDED;
                                expend_count_next = '0;
                                phase_next        = PH_IDLE;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            MODE_EXPENDED:
            begin
                if (expend_count_next != TMAX)
                    expend_count_next = expend_count_next + 1'b1;
                if (32'(expend_count_next) >= 32'(cfg.expended_ticks))
                    mode_next = MODE_SAFE;
            end
            default: ;
        endcase
    end

    // result of this tick
    always_comb
    begin
        res.mode        = mode_code(mode_next);
        res.ir_drive    = drive;
        res.safe_lamp   = (mode_next == MODE_SAFE);
        res.armed_lamp  = (mode_next == MODE_READY) || (mode_next == MODE_FLY) ||
                          (mode_next == MODE_SENSE) || (mode_next == MODE_FLASH);
        res.spent_lamp  = (mode_next == MODE_EXPENDED);
        res.shots       = SHOTS_W'(shot_total_next);
        res.confirmed   = confirm_flag_next;
        res.burst_start = start;
    end

    // state update once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_SAFE;
            phase_reg        <= PH_IDLE;
            power_held_reg   <= 1'b0;
            hold_count_reg   <= '0;
            expend_count_reg <= '0;
            bit_position_reg <= '0;
            bin_count_reg    <= '0;
            window_count_reg <= '0;
            shot_total_reg   <= '0;
            confirm_flag_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg         <= mode_next;
            phase_reg        <= phase_next;
            power_held_reg   <= power_held_next;
            hold_count_reg   <= hold_count_next;
            expend_count_reg <= expend_count_next;
            bit_position_reg <= bit_position_next;
            bin_count_reg    <= bin_count_next;
            window_count_reg <= window_count_next;
            shot_total_reg   <= shot_total_next;
            confirm_flag_reg <= confirm_flag_next;
        end
    end

endmodule

`default_nettype wire

### rtl/arming_sequencer_ir_burst_unit.sv
// Arming sequencer with IR burst, one request per 1 us tick.
// Channels: item (sink) carries the sampled button, switch and sense levels
// of one tick; result (source) carries mode, emitter level, LEDs, shot count,
// confirm flag and burst start for that tick; cfg (sink) writes one register
// by index, always ready, indexes past the last register are dropped.
// The result of a request is in the output register the cycle after it is
// accepted. Throughput: one request per cycle while results are taken, set
// by the single registered pass of next-state logic over the sequence state.
// The output register decouples the sides: a new request is accepted while
// a result is being taken in the same cycle; when the receiver stalls, the
// result holds and item.ready drops until it is taken.
// Reset (rst_n low, asynchronous) returns the sequence to safe with all
// counters cleared, the output register empty and the registers at their
// default values. No clearing pass is needed.
// The user must write registers only while no request is in flight; the block itself does not enforce this.
`default_nettype none
`include "arming_sequencer_ir_burst_unit_defines.svh"

module arming_sequencer_ir_burst_unit #(
    parameter int CODE_LEN   = asib_pkg::DEF_CODE_LEN,
    parameter int SIDE_BIT   = asib_pkg::DEF_SIDE_BIT,
    parameter int LEAD_TICKS = asib_pkg::DEF_LEAD_TICKS,
    parameter int TIMER_BITS = asib_pkg::DEF_TIMER_BITS,
    parameter int COUNT_BITS = asib_pkg::DEF_COUNT_BITS
) (
    input wire logic     clk,
    input wire logic     rst_n,
    asib_chan_if.sink    item,
    asib_chan_if.source  result,
    asib_chan_if.sink    cfg
);
    import asib_pkg::*;

    asib_cfg_t    cfg_cur;
    asib_result_t step_res;
    logic         step;
    logic         cfg_wr_en;
    logic         result_valid_reg, result_valid_next;
    asib_result_t result_data_reg;
    logic         burst_seen;
    logic         start_mode_ok;
    logic         lamps_onehot;

    // configuration port
    assign cfg.ready = 1'b1;
    assign cfg_wr_en = cfg.valid && cfg.ready;

    asib_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg_wr_en),
        .wr    (cfg.data),
        .cfg   (cfg_cur)
    );

    // request acceptance
    assign item.ready = !result_valid_reg || result.ready;
    assign step       = item.valid && item.ready;

    asib_seq #(
        .CODE_LEN   (CODE_LEN),
        .SIDE_BIT   (SIDE_BIT),
        .LEAD_TICKS (LEAD_TICKS),
        .TIMER_BITS (TIMER_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item.data),
        .cfg   (cfg_cur),
        .res   (step_res)
    );

    // output register valid
    always_comb
    begin
        if (step)
            result_valid_next = 1'b1;
        else if (result.ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (step)
            result_data_reg <= step_res;
    end

    assign result.valid = result_valid_reg;
    assign result.data  = result_data_reg;

    // checks
    assign burst_seen    = result.valid && result.data.burst_start;
    assign start_mode_ok = (result.data.mode == MODE_CODE_FLASH) ||
                           (result.data.mode == MODE_CODE_EXPENDED);
    assign lamps_onehot  = $onehot({result.data.safe_lamp, result.data.armed_lamp,
                                    result.data.spent_lamp});

    `ASIB_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, step, result.valid, "request lost")
    `ASIB_ASSERT_IMPLY(a_burst_in_flash, clk, rst_n, burst_seen, start_mode_ok, "burst outside flash")
    `ASIB_ASSERT_IMPLY(a_lamp_decode, clk, rst_n, result.valid, lamps_onehot, "lamps not one-hot")

endmodule

`default_nettype wire
